// File: design/packet_fifo_queue_defines.svh
// Assertion macros shared by the packet FIFO queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PACKET_FIFO_QUEUE_DEFINES_SVH
`define PACKET_FIFO_QUEUE_DEFINES_SVH

// ante holds at an edge -> cons holds at the same edge
`define PFQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// expr never holds outside reset
`define PFQ_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

`endif

// File: design/pfq_pkg.sv
// Shared constants, codes and control structs of the packet FIFO queue.
// No dependencies; imported by the controller, datapath and top level.
package pfq_pkg;

    localparam int PFQ_SLOTS_DEF     = 16;
    localparam int PFQ_MAX_BYTES_DEF = 64;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DATA     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic push;        // store one pushed word
        logic emit_empty;  // load an empty status result
        logic load_len;    // latch head packet length, reset read index
        logic stream;      // read head packet bytes
        logic retire;      // free the head slot
    } pfq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic empty;       // no packet stored
        logic stream_done; // last byte of the packet moves to the output
    } pfq_sts_t;

endpackage

// File: design/pfq_ctrl.sv
// Controller state machine of the packet FIFO queue.
// Depends on pfq_pkg; drives the command struct of pfq_datapath.
module pfq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_func,
    input  pfq_pkg::pfq_sts_t sts,
    output pfq_pkg::pfq_cmd_t cmd
);
    import pfq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       remove_reg, remove_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        remove_next = remove_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_func) inside
                        FUNC_PUSH: cmd.push = 1'b1;
                        FUNC_DEQ, FUNC_PEEK: begin
                            if (sts.empty) begin
                                cmd.emit_empty = 1'b1;
                            end else begin
                                remove_next = (s_func == FUNC_DEQ);
                                state_next  = S_LEN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LEN: begin
                cmd.load_len = 1'b1;
                state_next   = S_STREAM;
            end
            S_STREAM: begin
                cmd.stream = 1'b1;
                if (sts.stream_done) begin
                    cmd.retire = remove_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            remove_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            remove_reg <= remove_next;
        end
    end

endmodule

// File: design/pfq_datapath.sv
// Datapath of the packet FIFO queue: packet store, length table, slot
// pointers, read pipeline and output register. Depends on pfq_pkg.
`include "packet_fifo_queue_defines.svh"

module pfq_datapath #(
    parameter int Slots    = pfq_pkg::PFQ_SLOTS_DEF,
    parameter int MaxBytes = pfq_pkg::PFQ_MAX_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pfq_pkg::pfq_cmd_t              cmd,
    output pfq_pkg::pfq_sts_t              sts,
    input  logic [pfq_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pfq_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last,
    output logic [pfq_pkg::PLEN_W-1:0]     out_len,
    output logic [pfq_pkg::STATUS_W-1:0]   out_status
);
    import pfq_pkg::*;

    localparam int Depth  = Slots * MaxBytes;
    localparam int ADDR_W = $clog2(Depth);
    localparam int SLOT_W = $clog2(Slots);
    localparam int CNT_W  = $clog2(Slots + 1);
    localparam int LEN_W  = $clog2(MaxBytes + 1);

    logic [BYTE_W-1:0] store_mem [Depth];
    logic [LEN_W-1:0]  len_mem   [Slots];

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  woff_reg, woff_next;
    logic              ovf_reg, ovf_next;

    logic              full;
    logic              wr_en, len_wr;
    logic              push_res, push_drop;
    logic [LEN_W-1:0]  push_len;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    // read pipeline
    logic [LEN_W-1:0]  len_rd_reg;
    logic [LEN_W-1:0]  slen_reg;
    logic [LEN_W-1:0]  ridx_reg;
    logic              pend_reg;
    logic              pend_last_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              issue, move, out_free;

    // output register
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic [PLEN_W-1:0]   out_len_reg;
    logic [STATUS_W-1:0] out_status_reg;

    assign full     = (cnt_reg == CNT_W'(Slots));
    assign out_free = !out_valid_reg || out_ready;
    assign move     = pend_reg && out_free;
    assign issue    = cmd.stream && (ridx_reg != slen_reg) && (!pend_reg || move);

    assign wr_addr = ADDR_W'(tail_reg) * ADDR_W'(MaxBytes) + ADDR_W'(woff_reg);
    assign rd_addr = ADDR_W'(head_reg) * ADDR_W'(MaxBytes) + ADDR_W'(ridx_reg);

    assign sts.out_free    = out_free;
    assign sts.empty       = (cnt_reg == '0);
    assign sts.stream_done = move && pend_last_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        woff_next = woff_reg;
        ovf_next  = ovf_reg;
        wr_en     = 1'b0;
        len_wr    = 1'b0;
        push_res  = 1'b0;
        push_drop = 1'b0;
        push_len  = woff_reg;
        if (cmd.push) begin
            // count saturates at the maximum length
            if (woff_reg >= LEN_W'(MaxBytes)) begin
                ovf_next = 1'b1;
            end else begin
                if (full) begin
                    ovf_next = 1'b1;
                end else begin
                    wr_en = 1'b1;
                end
                woff_next = woff_reg + 1'b1;
            end
            if (in_last) begin
                push_res  = 1'b1;
                push_len  = woff_next;
                push_drop = ovf_next || full;
                if (!push_drop) begin
                    len_wr    = 1'b1;
                    tail_next = (tail_reg == SLOT_W'(Slots - 1)) ? '0 : tail_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                woff_next = '0;
                ovf_next  = 1'b0;
            end
        end
        if (cmd.retire) begin
            head_next = (head_reg == SLOT_W'(Slots - 1)) ? '0 : head_reg + 1'b1;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            woff_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            woff_reg <= woff_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= in_byte;
        end
        if (issue) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_wr) begin
            len_mem[tail_reg] <= push_len;
        end
        len_rd_reg <= len_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_len) begin
            slen_reg <= len_rd_reg;
        end
        if (issue) begin
            pend_last_reg <= (ridx_reg + 1'b1 == slen_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ridx_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (cmd.load_len) begin
                ridx_reg <= '0;
            end else if (issue) begin
                ridx_reg <= ridx_reg + 1'b1;
            end
            if (issue) begin
                pend_reg <= 1'b1;
            end else if (move) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move || cmd.emit_empty || push_res) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= pend_last_reg;
            out_len_reg    <= PLEN_W'(slen_reg);
            out_status_reg <= ST_DATA;
        end else if (cmd.emit_empty) begin
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_len_reg    <= '0;
            out_status_reg <= ST_EMPTY;
        end else if (push_res) begin
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_len_reg    <= PLEN_W'(push_len);
            out_status_reg <= push_drop ? ST_DROPPED : ST_ACCEPTED;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_len    = out_len_reg;
    assign out_status = out_status_reg;

    `PFQ_ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CNT_W'(Slots),
        "packet count exceeds slot count")
    `PFQ_ASSERT_IMPL(a_empty_ptrs, aclk, aresetn, cnt_reg == '0, head_reg == tail_reg,
        "empty queue with head and tail apart")
    `PFQ_ASSERT_IMPL(a_res_slot, aclk, aresetn, cmd.emit_empty || push_res || move,
        out_free, "result loaded while output word still held")
    `PFQ_ASSERT_IMPL(a_push_idle, aclk, aresetn, cmd.push,
        !cmd.stream && !pend_reg, "push word taken during a packet read")

endmodule

// File: design/packet_fifo_queue.sv
// Top level of the packet FIFO queue: store-and-forward queue of whole packets.
// Depends on pfq_pkg, pfq_ctrl and pfq_datapath.
//
//  channel | dir | tdata                               | tlast      | tuser
//  s_      | in  | [7:0] data_byte                     | last_byte  | [1:0] func
//  m_      | out | [7:0] out_byte, [14:8] packet_length | out_last   | [1:0] status
//
// Push and func 3 words leave the controller idle; a closing push gives its status word
// out of the output register the next cycle.
// Dequeue/peek: after the take, S_LEN latches the head length and the store read is
// registered, then one byte per cycle moves out while m_tready does not stall it.
// An empty dequeue/peek stays in idle. A new word is taken only between reads.
// Reset (aresetn low, synchronous) empties the queue at once; no clearing pass.
// m_tready low stalls the read stream and holds s_tready low until a word is taken.
module packet_fifo_queue #(
    parameter int PACKET_SLOTS     = pfq_pkg::PFQ_SLOTS_DEF,
    parameter int MAX_PACKET_BYTES = pfq_pkg::PFQ_MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] packet_length, [15] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);
    import pfq_pkg::*;

    pfq_cmd_t            cmd;
    pfq_sts_t            sts;
    logic [BYTE_W-1:0]   out_byte;
    logic [PLEN_W-1:0]   out_len;
    logic [STATUS_W-1:0] out_status;

    pfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfq_datapath #(
        .Slots    (PACKET_SLOTS),
        .MaxBytes (MAX_PACKET_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_len    (out_len),
        .out_status (out_status)
    );

    assign m_tdata = {1'b0, out_len, out_byte};
    assign m_tuser = out_status;

endmodule

// File: sim/pfq_checker.sv
`timescale 1ns / 100ps
// Checker for the packet FIFO queue: watches both stream channels, predicts result words.
// Compares each result field by field. Depends on pfq_pkg only.
module pfq_checker #(
    parameter int SLOTS = pfq_pkg::PFQ_SLOTS_DEF,
    parameter int MAXB  = pfq_pkg::PFQ_MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] packet_length, [15] zero
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fails,
    output int          pending,
    output int          results_seen,
    output int          drops_seen
);
    import pfq_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [PLEN_W-1:0]   plen;
        logic [STATUS_W-1:0] status;
    } pfq_word_t;

    // shadow copy of the queue
    logic [BYTE_W-1:0] shadow_store [SLOTS*MAXB];
    logic [PLEN_W-1:0] shadow_len [SLOTS];
    int head_slot, tail_slot, held, wr_count;
    bit overflow;

    pfq_word_t expected_words [$];
    pfq_word_t got, want;
    int fail_cnt = 0;
    int result_cnt = 0;
    int drop_cnt = 0;

    function automatic pfq_word_t status_word(input int plen, input logic [STATUS_W-1:0] st);
        pfq_word_t w;
        w.data   = '0;
        w.last   = 1'b1;
        w.plen   = PLEN_W'(plen);
        w.status = st;
        return w;
    endfunction

    task automatic predict_push(input logic [BYTE_W-1:0] d, input logic fin);
        bit full;
        full = (held >= SLOTS);
        if (wr_count >= MAXB) begin
            overflow = 1'b1;
        end else begin
            if (full)
                overflow = 1'b1;
            else
                shadow_store[tail_slot*MAXB + wr_count] = d;
            wr_count++;
        end
        if (!fin)
            return;
        // count saturates at MAXB, so an overlong drop reports MAXB
        if (overflow || full) begin
            expected_words.push_back(status_word(wr_count, ST_DROPPED));
        end else begin
            shadow_len[tail_slot] = PLEN_W'(wr_count);
            tail_slot = (tail_slot + 1) % SLOTS;
            held++;
            expected_words.push_back(status_word(wr_count, ST_ACCEPTED));
        end
        wr_count = 0;
        overflow = 1'b0;
    endtask

    task automatic predict_read(input bit remove);
        int len;
        int i;
        pfq_word_t w;
        if (held == 0) begin
            expected_words.push_back(status_word(0, ST_EMPTY));
            return;
        end
        len = shadow_len[head_slot];
        for (i = 0; i < len; i++) begin
            w.data   = shadow_store[head_slot*MAXB + i];
            w.last   = (i == len - 1);
            w.plen   = PLEN_W'(len);
            w.status = ST_DATA;
            expected_words.push_back(w);
        end
        if (remove) begin
            head_slot = (head_slot + 1) % SLOTS;
            held--;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_slot = 0;
            tail_slot = 0;
            held      = 0;
            wr_count  = 0;
            overflow  = 1'b0;
            expected_words.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    FUNC_PUSH: predict_push(s_tdata, s_tlast);
                    FUNC_DEQ:  predict_read(1'b1);
                    FUNC_PEEK: predict_read(1'b0);
                    default:   ;  // unused func: no effect
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.data   = m_tdata[7:0];
                got.last   = m_tlast;
                got.plen   = m_tdata[14:8];
                got.status = m_tuser;
                result_cnt++;
                if (got.status == ST_DROPPED)
                    drop_cnt++;
                if (expected_words.size() == 0) begin
                    fail_cnt++;
                    $display("%0t checker: unexpected word data=%02h last=%0d len=%0d st=%0d",
                             $time, got.data, got.last, got.plen, got.status);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        $display("%0t checker: mismatch exp data=%02h last=%0d len=%0d st=%0d",
                                 $time, want.data, want.last, want.plen, want.status);
                        $display("%0t checker:          got data=%02h last=%0d len=%0d st=%0d",
                                 $time, got.data, got.last, got.plen, got.status);
                    end
                end
            end
        end
        fails        <= fail_cnt;
        pending      <= expected_words.size();
        results_seen <= result_cnt;
        drops_seen   <= drop_cnt;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for packet_fifo_queue: clock, reset, stream stimulus and verdict.
// Depends on pfq_pkg, the packet_fifo_queue RTL and pfq_checker.
module tb;
    import pfq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int MAXB        = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused code, block ignores it

    typedef enum {SINK_RANDOM, SINK_HOLD, SINK_ALWAYS} sink_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_byte, [14:8] packet_length, [15] zero
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [1:0] status

    int fails, pending, results_seen, drops_seen;
    int items_sent, n_push, n_deq, n_peek, n_none;
    int quiet;
    bit src_gaps;
    bit hold_on;
    bit hold_over;
    sink_mode_t sink_mode;

    packet_fifo_queue #(
        .PACKET_SLOTS(SLOTS),
        .MAX_PACKET_BYTES(MAXB)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    pfq_checker #(.SLOTS(SLOTS), .MAXB(MAXB)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .fails(fails), .pending(pending),
        .results_seen(results_seen), .drops_seen(drops_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stall bursts, one long hold-off, no stalls at the end
    initial begin
        hold_on   = 1'b0;
        hold_over = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_mode == SINK_HOLD && !hold_over) begin
                m_tready <= 1'b0;
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_over = 1'b1;
            end else if (sink_mode == SINK_RANDOM && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else if (sink_mode == SINK_ALWAYS) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t watchdog: no traffic for %0d cycles, %0d words pending",
                         $time, quiet, pending);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [7:0] d,
                             input logic fin);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= d;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (func)
            FUNC_PUSH: n_push++;
            FUNC_DEQ:  n_deq++;
            FUNC_PEEK: n_peek++;
            default:   n_none++;
        endcase
        if (func != FUNC_NONE)
            items_sent++;
    endtask

    // random bytes; optionally a dequeue or peek slipped in while the packet is open
    task automatic send_packet(input int len, input bit mid_read);
        int i;
        int at;
        at = $urandom_range(1, (len > 1) ? len - 1 : 1);
        for (i = 0; i < len; i++) begin
            if (mid_read && i == at)
                send_word($urandom_range(0, 1) ? FUNC_DEQ : FUNC_PEEK, 8'($urandom), 1'($urandom));
            send_word(FUNC_PUSH, 8'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_traffic(input int n);
        int first;
        int r;
        int len;
        first = items_sent;
        while (items_sent - first < n) begin
            r = $urandom_range(0, 11);
            if (r < 5) begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(1, 6);
                send_packet(len, $urandom_range(0, 3) == 0);
            end else if (r < 8) begin
                send_word(FUNC_DEQ, 8'($urandom), 1'($urandom));
            end else if (r < 10) begin
                send_word(FUNC_PEEK, 8'($urandom), 1'($urandom));
            end else if (r == 10) begin
                send_word(FUNC_NONE, 8'($urandom), 1'($urandom));
            end else begin
                send_word(FUNC_DEQ, 8'($urandom), 1'($urandom));
                send_word(FUNC_DEQ, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int i;
        items_sent = 0;
        n_push     = 0;
        n_deq      = 0;
        n_peek     = 0;
        n_none     = 0;
        src_gaps   = 1'b0;
        sink_mode  = SINK_RANDOM;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= FUNC_PUSH;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty reads, unused func, byte extremes, read during an open packet
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_PEEK, 8'hFF, 1'b1);
        send_word(FUNC_NONE, 8'hFF, 1'b1);
        send_word(FUNC_NONE, 8'h00, 1'b0);
        send_word(FUNC_PUSH, 8'h00, 1'b1);
        send_word(FUNC_PUSH, 8'hFF, 1'b1);
        send_word(FUNC_PUSH, 8'hA5, 1'b0);
        send_word(FUNC_PUSH, 8'h5A, 1'b0);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_PUSH, 8'h3C, 1'b1);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        wait_drained;

        // maximum length accepted, one byte more dropped with the saturated length
        src_gaps = 1'b1;
        send_packet(MAXB, 1'b0);
        send_packet(MAXB + 1, 1'b0);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        wait_drained;

        // fill every slot; a packet started while full stays dropped after a slot frees
        for (i = 0; i < SLOTS; i++)
            send_packet(1, 1'b0);
        send_word(FUNC_PUSH, 8'($urandom), 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_PUSH, 8'($urandom), 1'b1);
        send_packet(2, 1'b0);
        send_packet(1, 1'b0);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        for (i = 0; i <= SLOTS; i++)
            send_word(FUNC_DEQ, 8'h00, 1'b0);
        wait_drained;

        // long hold-off on the result side while words keep coming
        sink_mode = SINK_HOLD;
        wait (hold_on);
        for (i = 0; i < 2; i++)
            send_packet(2, 1'b0);
        send_word(FUNC_DEQ, 8'h00, 1'b0);
        send_word(FUNC_PEEK, 8'h00, 1'b0);
        wait (hold_over);
        sink_mode = SINK_RANDOM;
        wait_drained;

        random_traffic(10);
        src_gaps  = 1'b0;
        sink_mode = SINK_ALWAYS;
        random_traffic(6);
        wait_drained;
        repeat (20) @(posedge aclk);

        $display("summary: %0d words in (%0d push, %0d dequeue, %0d peek, %0d unused func)",
                 n_push + n_deq + n_peek + n_none, n_push, n_deq, n_peek, n_none);
        $display("summary: %0d result words checked, %0d drops, full queue and output stall hit",
                 results_seen, drops_seen);
        if (fails == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
